FILE: rtl/sorted_range_table_lookup_macros.svh
// Assertion macros shared by the sorted range table lookup modules.
// Each macro expects signals named clock and reset in the including module.
`ifndef SORTED_RANGE_TABLE_LOOKUP_MACROS_SVH
`define SORTED_RANGE_TABLE_LOOKUP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SRTL_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SRTL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SRTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/srtl_pkg.sv
// Shared types and constants for the sorted range table lookup block.
// Used by the controller, the datapath and the top level; depends on nothing.
package srtl_pkg;

   localparam int ADDR_BITS     = 32;
   localparam int TAG_PORT_BITS = 16;

   localparam logic [ADDR_BITS-1:0] SENTINEL_ADDR = '1;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // Which result the datapath loads into the output register.
   typedef enum logic [1:0] {
      RES_INSERT_OK,
      RES_FULL,
      RES_MISS,
      RES_LOOKUP
   } res_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_req;
      logic        search_rd;
      logic        search_upd;
      logic        probe_rd;
      logic        shift_init;
      logic        shift_rd;
      logic        ins_wr;
      logic        res_load;
      res_sel_type res_sel;
   } srtl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_query;
      logic sentinel;
      logic empty;
      logic full;
      logic lo_lt_hi;
      logic lo_zero;
      logic ptr_above;
   } srtl_status_type;

endpackage

FILE: rtl/srtl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; depends on nothing.
module srtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/srtl_ctrl.sv
// Controller state machine of the sorted range table lookup block.
// Depends on srtl_pkg and the shared assertion macro header.
`include "sorted_range_table_lookup_macros.svh"

module srtl_ctrl
   import srtl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  srtl_status_type status,
   output srtl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_SHIFT,
      ST_INS_WR,
      ST_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   res_sel_type res_sel_ff, res_sel_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      res_sel_in   = res_sel_ff;
      cmd          = '0;
      cmd.res_sel  = res_sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_query && (status.sentinel || status.empty)) begin
               res_sel_in = RES_MISS;
               state_in   = ST_FINISH;
            end else if (!status.is_query && status.full) begin
               res_sel_in = RES_FULL;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_SEARCH_RD;
            end
         end
         ST_SEARCH_RD: begin
            if (status.lo_lt_hi) begin
               cmd.search_rd = 1'b1;
               state_in      = ST_SEARCH_CMP;
            end else if (status.is_query) begin
               if (status.lo_zero) begin
                  res_sel_in = RES_MISS;
               end else begin
                  cmd.probe_rd = 1'b1;
                  res_sel_in   = RES_LOOKUP;
               end
               state_in = ST_FINISH;
            end else begin
               cmd.shift_init = 1'b1;
               state_in       = ST_SHIFT;
            end
         end
         ST_SEARCH_CMP: begin
            cmd.search_upd = 1'b1;
            state_in       = ST_SEARCH_RD;
         end
         ST_SHIFT: begin
            if (status.ptr_above) begin
               cmd.shift_rd = 1'b1;
            end else begin
               state_in = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cmd.ins_wr = 1'b1;
            res_sel_in = RES_INSERT_OK;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         res_sel_ff   <= RES_MISS;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         res_sel_ff   <= res_sel_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SRTL_ASSERT_NEXT(a_one_item_at_a_time, req_valid && !req_stall, req_stall, "second item taken while busy")

endmodule

FILE: rtl/srtl_dp.sv
// Datapath of the sorted range table lookup block: search bounds, entry count,
// shift pointer, result registers and the table memory. Depends on srtl_pkg,
// srtl_ram and the shared assertion macro header.
`include "sorted_range_table_lookup_macros.svh"

module srtl_dp
   import srtl_pkg::*;
#(
   parameter int TABLE_DEPTH = 2048,
   parameter int TAG_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srtl_cmd_type             cmd,
   input  logic                     req_action,
   input  logic [ADDR_BITS-1:0]     req_range_begin,
   input  logic [ADDR_BITS-1:0]     req_range_end,
   input  logic [TAG_PORT_BITS-1:0] req_entry_tag,
   input  logic [ADDR_BITS-1:0]     req_query_addr,
   output srtl_status_type          status,
   output logic [1:0]               rsp_status,
   output logic [ADDR_BITS-1:0]     rsp_found_base,
   output logic [TAG_PORT_BITS-1:0] rsp_found_tag,
   output logic [ADDR_BITS-1:0]     rsp_found_offset
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   // Only the low TAG_BITS bits of the tag port are kept, or all of them if the port is narrower.
   localparam int SW = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;
   localparam int WW = 2 * ADDR_BITS + SW;

   logic                 action_ff;
   logic [ADDR_BITS-1:0] key_ff;
   logic [ADDR_BITS-1:0] begin_ff;
   logic [ADDR_BITS-1:0] end_ff;
   logic [SW-1:0]        tag_ff;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        mid_ff;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 pend_ff;
   logic [IW-1:0]        pend_addr_ff;

   logic [1:0]               status_ff, status_in;
   logic [ADDR_BITS-1:0]     base_ff, base_in;
   logic [TAG_PORT_BITS-1:0] found_tag_ff, found_tag_in;
   logic [ADDR_BITS-1:0]     offset_ff, offset_in;

   logic [CW-1:0]        mid_calc;
   logic [CW-1:0]        lo_m1;
   logic [CW-1:0]        ptr_m1;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   logic [WW-1:0]        rd_data;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [WW-1:0]        wr_data;
   logic [ADDR_BITS-1:0] rd_start;
   logic [ADDR_BITS-1:0] rd_stop;
   logic [SW-1:0]        rd_tag;
   logic                 hit;

   assign rd_start = rd_data[WW-1 -: ADDR_BITS];
   assign rd_stop  = rd_data[SW +: ADDR_BITS];
   assign rd_tag   = rd_data[SW-1:0];

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1    = lo_ff - CW'(1);
   assign ptr_m1   = ptr_ff - CW'(1);

   always_comb begin
      rd_en   = cmd.search_rd || cmd.probe_rd || cmd.shift_rd;
      rd_addr = mid_calc[IW-1:0];
      if (cmd.probe_rd) begin
         rd_addr = lo_m1[IW-1:0];
      end else if (cmd.shift_rd) begin
         rd_addr = ptr_m1[IW-1:0];
      end
   end

   // A shifted entry is written one slot up the cycle after it was read.
   always_comb begin
      wr_en   = cmd.ins_wr || pend_ff;
      wr_addr = pend_addr_ff;
      wr_data = rd_data;
      if (cmd.ins_wr) begin
         wr_addr = lo_ff[IW-1:0];
         wr_data = {begin_ff, end_ff, tag_ff};
      end
   end

   srtl_ram #(
      .WIDTH (WW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      if (cmd.load_req) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.search_upd) begin
         if (rd_start <= key_ff) begin
            lo_in = mid_ff + CW'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.shift_init) begin
         ptr_in = count_ff;
      end
      if (cmd.shift_rd) begin
         ptr_in = ptr_m1;
      end
      if (cmd.ins_wr) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         lo_ff    <= '0;
         hi_ff    <= '0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= cmd.shift_rd;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load_req) begin
         action_ff <= req_action;
         key_ff    <= (req_action == ACTION_QUERY) ? req_query_addr : req_range_begin;
         begin_ff  <= req_range_begin;
         end_ff    <= req_range_end;
         tag_ff    <= req_entry_tag[SW-1:0];
      end
      if (cmd.search_rd) begin
         mid_ff <= mid_calc;
      end
      if (cmd.shift_rd) begin
         pend_addr_ff <= ptr_ff[IW-1:0];
      end
   end

   assign hit = (key_ff >= rd_start) && (key_ff < rd_stop);

   always_comb begin
      status_in    = STATUS_MISS;
      base_in      = SENTINEL_ADDR;
      found_tag_in = '0;
      offset_in    = '0;
      case (cmd.res_sel)
         RES_INSERT_OK: begin
            status_in = STATUS_OK;
         end
         RES_FULL: begin
            status_in = STATUS_FULL;
         end
         RES_LOOKUP: begin
            if (hit) begin
               status_in    = STATUS_OK;
               base_in      = rd_start;
               found_tag_in = TAG_PORT_BITS'(rd_tag);
               offset_in    = key_ff - rd_start;
            end
         end
         default: begin
            status_in = STATUS_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         status_ff    <= status_in;
         base_ff      <= base_in;
         found_tag_ff <= found_tag_in;
         offset_ff    <= offset_in;
      end
   end

   assign status.is_query  = (action_ff == ACTION_QUERY);
   assign status.sentinel  = (key_ff == SENTINEL_ADDR);
   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff == CW'(TABLE_DEPTH));
   assign status.lo_lt_hi  = (lo_ff < hi_ff);
   assign status.lo_zero   = (lo_ff == '0);
   assign status.ptr_above = (ptr_ff > lo_ff);

   assign rsp_status       = status_ff;
   assign rsp_found_base   = base_ff;
   assign rsp_found_tag    = found_tag_ff;
   assign rsp_found_offset = offset_ff;

   `SRTL_ASSERT_SAME(a_single_write, cmd.ins_wr, !pend_ff, "insert write collides with shift write")
   `SRTL_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(TABLE_DEPTH), "entry count beyond depth")
   `SRTL_ASSERT_NEXT(a_bounds_order, cmd.search_upd, lo_ff <= hi_ff, "search bounds crossed")
   `SRTL_ASSERT_SAME(a_shift_range, cmd.shift_rd, ptr_ff > lo_ff, "shift read below insert slot")

endmodule

FILE: rtl/sorted_range_table_lookup.sv
// Top level of the sorted range table lookup block.
// Depends on srtl_pkg, srtl_ctrl, srtl_dp and srtl_ram.
//
// The block keeps up to TABLE_DEPTH address ranges sorted on their start
// address in one simple dual-port memory. An insert item places a range at
// its sorted position, after any entry with the same start, and answers
// status ok, or table full when no room is left. A query item answers with
// the start, tag and offset of the last range that starts at or below the
// address, if that range holds it, or with not found. A query runs a binary
// search over the entries; an insert runs the same search, then moves each
// entry at or above the insert slot one slot up and writes the new range.
// Each binary search step has a read state and a compare state, because
// the table memory has a registered read that feeds the compare; the insert
// shift is paced by the single read and write port of the memory.
// Items are handled one at a time. The next item is accepted while a result
// still waits in the output register. The table contents need no clearing
// after reset, since the entry count is reset to zero.
module sorted_range_table_lookup
   import srtl_pkg::*;
#(
   parameter int TABLE_DEPTH = 2048,
   parameter int TAG_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [ADDR_BITS-1:0]     req_range_begin,
   input  logic [ADDR_BITS-1:0]     req_range_end,
   input  logic [TAG_PORT_BITS-1:0] req_entry_tag,
   input  logic [ADDR_BITS-1:0]     req_query_addr,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [ADDR_BITS-1:0]     rsp_found_base,
   output logic [TAG_PORT_BITS-1:0] rsp_found_tag,
   output logic [ADDR_BITS-1:0]     rsp_found_offset
);

   // The controller sequences each item; the datapath holds every register
   // that carries data, including the search bounds and the entry count.
   srtl_cmd_type    cmd;
   srtl_status_type status;

   srtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srtl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_range_begin  (req_range_begin),
      .req_range_end    (req_range_end),
      .req_entry_tag    (req_entry_tag),
      .req_query_addr   (req_query_addr),
      .status           (status),
      .rsp_status       (rsp_status),
      .rsp_found_base   (rsp_found_base),
      .rsp_found_tag    (rsp_found_tag),
      .rsp_found_offset (rsp_found_offset)
   );

endmodule

FILE: sim/tb_sorted_range_table_lookup.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted range table lookup block.
// Depends on srtl_pkg and the block's RTL; keeps its own sorted range table to predict results.
module tb_sorted_range_table_lookup;
   import srtl_pkg::*;

   localparam int TABLE_DEPTH = 2048;
   localparam int TAG_BITS    = 16;

   // Only the low TAG_BITS bits of a tag are stored by the block.
   localparam logic [TAG_PORT_BITS-1:0] TAG_KEEP = TAG_PORT_BITS'((64'd1 << TAG_BITS) - 1);

   localparam int RANDOM_PHASE_ITEMS = 282;
   localparam int HOLD_OFF_CYCLES    = 400;
   localparam int DRAIN_CYCLES       = 50;

   typedef struct {
      logic                     action;
      logic [ADDR_BITS-1:0]     range_begin;
      logic [ADDR_BITS-1:0]     range_end;
      logic [TAG_PORT_BITS-1:0] entry_tag;
      logic [ADDR_BITS-1:0]     query_addr;
   } lookup_item_type;

   typedef struct {
      logic [1:0]               status;
      logic [ADDR_BITS-1:0]     found_base;
      logic [TAG_PORT_BITS-1:0] found_tag;
      logic [ADDR_BITS-1:0]     found_offset;
   } lookup_rsp_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_action       = ACTION_INSERT;
   logic [ADDR_BITS-1:0]     req_range_begin  = '0;
   logic [ADDR_BITS-1:0]     req_range_end    = '0;
   logic [TAG_PORT_BITS-1:0] req_entry_tag    = '0;
   logic [ADDR_BITS-1:0]     req_query_addr   = '0;
   logic                     rsp_stall        = 1'b0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [ADDR_BITS-1:0]     rsp_found_base;
   logic [TAG_PORT_BITS-1:0] rsp_found_tag;
   logic [ADDR_BITS-1:0]     rsp_found_offset;

   sorted_range_table_lookup #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_range_begin  (req_range_begin),
      .req_range_end    (req_range_end),
      .req_entry_tag    (req_entry_tag),
      .req_query_addr   (req_query_addr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found_base   (rsp_found_base),
      .rsp_found_tag    (rsp_found_tag),
      .rsp_found_offset (rsp_found_offset)
   );

   // The testbench's own copy of the range table, sorted on start address.
   // It is updated when an item is accepted, in acceptance order, so the
   // expected result of every item reflects exactly the inserts before it.
   logic [ADDR_BITS-1:0]     model_start [TABLE_DEPTH];
   logic [ADDR_BITS-1:0]     model_end   [TABLE_DEPTH];
   logic [TAG_PORT_BITS-1:0] model_tag   [TABLE_DEPTH];
   int                       model_count = 0;

   // Items waiting to be offered, and results waiting to come out.
   lookup_item_type req_backlog [$];
   lookup_rsp_type  awaited_rsp [$];
   lookup_item_type driven_item;

   // Ranges handed to the sender so far. The generator draws query addresses
   // from these so that most queries land in or next to a stored range.
   logic [ADDR_BITS-1:0] planned_begin [$];
   logic [ADDR_BITS-1:0] planned_end   [$];
   int                   planned_count = 0;

   // Percentages of cycles in which the sender idles and the receiver
   // stalls; rsp_hold forces a long stall for the back-pressure check.
   int   send_idle_pct  = 0;
   int   rsp_stall_pct  = 0;
   logic rsp_hold       = 1'b0;
   int   mismatch_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Index of the first entry whose start lies above key, or the entry count
   // when there is none. The entry before it, if any, is the candidate range.
   function automatic int first_start_above(logic [ADDR_BITS-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = model_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (model_start[mid] <= key) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   // Applies one accepted item to the table and returns the result it causes.
   function automatic lookup_rsp_type apply_to_table(lookup_item_type item);
      lookup_rsp_type rsp;
      int             pos;
      rsp.status       = STATUS_MISS;
      rsp.found_base   = SENTINEL_ADDR;
      rsp.found_tag    = '0;
      rsp.found_offset = '0;
      if (item.action == ACTION_INSERT) begin
         if (model_count >= TABLE_DEPTH) begin
            rsp.status = STATUS_FULL;
         end else begin
            // A new range goes after every entry with the same start.
            pos = first_start_above(item.range_begin);
            for (int i = model_count; i > pos; i--) begin
               model_start[i] = model_start[i-1];
               model_end[i]   = model_end[i-1];
               model_tag[i]   = model_tag[i-1];
            end
            model_start[pos] = item.range_begin;
            model_end[pos]   = item.range_end;
            model_tag[pos]   = item.entry_tag & TAG_KEEP;
            model_count++;
            rsp.status = STATUS_OK;
         end
      end else if (item.query_addr != SENTINEL_ADDR && model_count != 0) begin
         // Only the last entry with the greatest start not above the address
         // is checked; an empty or inverted range there can never hit.
         pos = first_start_above(item.query_addr);
         if (pos != 0 && item.query_addr < model_end[pos-1]) begin
            rsp.status       = STATUS_OK;
            rsp.found_base   = model_start[pos-1];
            rsp.found_tag    = model_tag[pos-1];
            rsp.found_offset = item.query_addr - model_start[pos-1];
         end
      end
      return rsp;
   endfunction

   function automatic void plan_insert(logic [ADDR_BITS-1:0] range_begin,
                                       logic [ADDR_BITS-1:0] range_end,
                                       logic [TAG_PORT_BITS-1:0] tag);
      lookup_item_type item;
      item.action      = ACTION_INSERT;
      item.range_begin = range_begin;
      item.range_end   = range_end;
      item.entry_tag   = tag;
      item.query_addr  = $urandom;
      req_backlog.push_back(item);
      if (planned_count < TABLE_DEPTH) begin
         planned_count++;
         planned_begin.push_back(range_begin);
         planned_end.push_back(range_end);
      end
   endfunction

   function automatic void plan_query(logic [ADDR_BITS-1:0] addr);
      lookup_item_type item;
      item.action      = ACTION_QUERY;
      item.range_begin = $urandom;
      item.range_end   = $urandom;
      item.entry_tag   = TAG_PORT_BITS'($urandom);
      item.query_addr  = addr;
      req_backlog.push_back(item);
   endfunction

   // Starts cluster in a few regions so that ranges overlap, share starts
   // and shadow one another; lengths cover short, long, empty and inverted.
   function automatic void plan_random_insert();
      logic [ADDR_BITS-1:0] range_begin;
      logic [ADDR_BITS-1:0] range_end;
      int                   pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         range_begin = $urandom;
      end else if (pick < 60 && planned_begin.size() != 0) begin
         range_begin = planned_begin[$urandom_range(planned_begin.size() - 1)];
      end else if (pick < 85) begin
         range_begin = $urandom_range(32'h3_FFFF);
      end else if (pick < 88) begin
         range_begin = 32'hFFFF_FF00 | $urandom_range(255);
      end else if (pick < 94) begin
         range_begin = $urandom_range(15);
      end else begin
         range_begin = 32'h8000_0000 + $urandom_range(4095);
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
         range_end = range_begin + $urandom_range(4096, 1);
      end else if (pick < 70) begin
         range_end = range_begin + $urandom;
      end else if (pick < 80) begin
         range_end = range_begin;
      end else if (pick < 92) begin
         range_end = range_begin - $urandom_range(4096, 1);
      end else begin
         range_end = SENTINEL_ADDR;
      end
      plan_insert(range_begin, range_end, TAG_PORT_BITS'($urandom));
   endfunction

   // Most queries aim inside or at the edges of a range already planned.
   function automatic void plan_random_query();
      logic [ADDR_BITS-1:0] addr;
      logic [ADDR_BITS-1:0] range_begin;
      logic [ADDR_BITS-1:0] range_end;
      int                   pick;
      int                   k;
      pick = $urandom_range(99);
      if (pick < 60 && planned_begin.size() != 0) begin
         k           = $urandom_range(planned_begin.size() - 1);
         range_begin = planned_begin[k];
         range_end   = planned_end[k];
         case ($urandom_range(5))
            0: begin
               addr = range_begin;
            end
            1: begin
               addr = range_begin - 1;
            end
            2: begin
               addr = range_end;
            end
            3: begin
               addr = range_end - 1;
            end
            default: begin
               if (range_end > range_begin) begin
                  addr = range_begin + ($urandom % (range_end - range_begin));
               end else begin
                  addr = range_begin + $urandom_range(15);
               end
            end
         endcase
      end else if (pick < 85) begin
         addr = $urandom;
      end else if (pick < 90) begin
         addr = SENTINEL_ADDR;
      end else if (pick < 93) begin
         addr = '0;
      end else begin
         addr = $urandom_range(32'h4_0000);
      end
      plan_query(addr);
   endfunction

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Sender. An item is taken at an edge where valid is high and the block
   // does not stall; the table copy is updated right there, and the next item
   // (or an idle cycle) is chosen. A stalled item is held unchanged.
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsp.push_back(apply_to_table(driven_item));
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_item = req_backlog.pop_front();
               req_valid       <= 1'b1;
               req_action      <= driven_item.action;
               req_range_begin <= driven_item.range_begin;
               req_range_end   <= driven_item.range_end;
               req_entry_tag   <= driven_item.entry_tag;
               req_query_addr  <= driven_item.query_addr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Every result taken is compared with the oldest expectation;
   // the stall for the next cycle is drawn at random or forced by rsp_hold.
   always @(posedge clock) begin : check_rsp
      lookup_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result: status %0d base %h tag %h offset %h",
                           rsp_status, rsp_found_base, rsp_found_tag, rsp_found_offset);
               end
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_status !== want.status || rsp_found_base !== want.found_base ||
                   rsp_found_tag !== want.found_tag ||
                   rsp_found_offset !== want.found_offset) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result mismatch: expected status %0d base %h tag %h offset %h",
                              want.status, want.found_base, want.found_tag,
                              want.found_offset);
                     $display("                 actual   status %0d base %h tag %h offset %h",
                              rsp_status, rsp_found_base, rsp_found_tag, rsp_found_offset);
                  end
               end
            end
         end
         rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Stimulus. Changes to the backlog and to the idle settings are made at
   // the falling edge so that they never race with the clocked processes.
   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items, no idling. Queries on an empty table first, then an
      // address below every start, a second range with an equal start that
      // shadows the first, ranges at address zero and at the top of the
      // address space, inverted and empty ranges, and the sentinel address.
      plan_query(32'h0000_0000);
      plan_query(SENTINEL_ADDR);
      plan_insert(32'h0000_0100, 32'h0000_0200, 16'hFFFF);
      plan_query(32'h0000_0050);
      plan_query(32'h0000_0100);
      plan_insert(32'h0000_0100, 32'h0000_0180, 16'h1234);
      plan_query(32'h0000_017F);
      plan_query(32'h0000_01A0);
      plan_insert(32'h0000_0000, 32'h0000_0001, 16'h0000);
      plan_query(32'h0000_0000);
      plan_query(32'h0000_0001);
      plan_insert(32'h0000_5000, 32'h0000_4000, 16'hAAAA);
      plan_query(32'h0000_5000);
      plan_insert(32'h0000_6000, 32'h0000_6000, 16'h5555);
      plan_query(32'h0000_6000);
      plan_insert(32'h8000_0000, SENTINEL_ADDR, 16'h8001);
      plan_query(32'hFFFF_FFFE);
      plan_insert(32'hFFFF_FF00, SENTINEL_ADDR, 16'h00FF);
      plan_query(32'hFFFF_FFFE);
      plan_query(SENTINEL_ADDR);
      plan_insert(SENTINEL_ADDR, SENTINEL_ADDR, 16'h7FFF);
      plan_insert(32'h0000_7000, 32'h0000_0000, 16'h0001);
      plan_query(32'h7FFF_FFFF);
      wait_drained();

      // Random items in four idling phases. The table keeps growing across
      // them, so later phases search and shift a larger table.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 32;
               rsp_stall_pct = 32;
            end
         endcase
         repeat (RANDOM_PHASE_ITEMS) begin
            if ($urandom_range(99) < 45) begin
               plan_random_insert();
            end else begin
               plan_random_query();
            end
         end
         // With the sender offering items back to back, the receiver holds
         // off for a long stretch so that the output register fills and the
         // block has to stall its input.
         if (phase == 0) begin
            rsp_hold = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end
         wait_drained();
      end

      // Any result still coming out now has no expectation and is flagged.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Far beyond the slowest correct run, even with every insert shifting the
   // whole random-phase table and every idle setting at its worst.
   initial begin : watchdog
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sorted_range_table_lookup.f
+incdir+rtl
rtl/srtl_pkg.sv
rtl/srtl_ram.sv
rtl/srtl_ctrl.sv
rtl/srtl_dp.sv
rtl/sorted_range_table_lookup.sv
sim/tb_sorted_range_table_lookup.sv
